### rtl/core/bsi_pkg.sv
// shared types and constants for the binned sorted insert block
`default_nettype none
package bsi_pkg;

   localparam int MAX_CHANNELS_DEF  = 16;
   localparam int CHANNEL_DEPTH_DEF = 32;
   localparam int ENERGY_WIDTH_DEF  = 32;

   localparam int OP_W      = 2;
   localparam int SPIN_W    = 5;
   localparam int TAG_W     = 12;
   localparam int RCH_W     = 4;
   localparam int STATUS_W  = 2;
   localparam int CHAN_W    = 4;
   localparam int RANK_W    = 5;
   localparam int CHIDX_W   = 8;
   localparam int MODE_W    = 2;
   localparam int PCOUNT_W  = 5;
   localparam int LIMIT_W   = 6;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 6;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_READ   = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_RSVD  = 2'd3
   } status_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_TRIANGULAR = 2'd0,
      MODE_PROJECTION = 2'd1,
      MODE_SINGLE     = 2'd2,
      MODE_NONE       = 2'd3
   } mode_type;

   localparam logic [CSR_IDX_W-1:0] REG_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PCOUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_WALK,
      ST_WRITE,
      ST_LINK,
      ST_RESP,
      ST_READ
   } seq_state_type;

   // fixed-width part of one result
   typedef struct packed {
      status_type          status;
      logic [CHAN_W-1:0]   channel;
      logic [TAG_W-1:0]    tag;
      logic [RANK_W-1:0]   rank;
      logic                entry_valid;
      logic                last;
   } rsp_ctl_type;

endpackage
`default_nettype wire

### rtl/core/bsi_entry_mem.sv
// entry store: one write port, one registered read port
`default_nettype none
module bsi_entry_mem #(
   parameter int WORDS = 512,
   parameter int AW    = 9,
   parameter int DW    = 49
) (
   input  wire logic          clock,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data
);

   logic [DW-1:0] mem [WORDS];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### rtl/core/bsi_seq.sv
// list sequencer: insert walk, readout walk, clear, with head and fill tables
`default_nettype none
module bsi_seq #(
   parameter int MAX_CHANNELS  = bsi_pkg::MAX_CHANNELS_DEF,
   parameter int CHANNEL_DEPTH = bsi_pkg::CHANNEL_DEPTH_DEF,
   parameter int ENERGY_WIDTH  = bsi_pkg::ENERGY_WIDTH_DEF,
   parameter int AW            = 9,
   parameter int DW            = 49
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire bsi_pkg::op_type                 in_op,
   input  wire logic signed [ENERGY_WIDTH-1:0]  in_energy,
   input  wire logic [bsi_pkg::TAG_W-1:0]       in_tag,
   input  wire logic [bsi_pkg::CHIDX_W-1:0]     in_ch,
   input  wire logic [bsi_pkg::CHIDX_W-1:0]     in_nch,
   input  wire logic [bsi_pkg::LIMIT_W-1:0]     in_limit,
   input  wire logic                            can_push,
   output logic                                 busy,
   output logic                                 push,
   output bsi_pkg::rsp_ctl_type                 push_ctl,
   output logic signed [ENERGY_WIDTH-1:0]       push_energy,
   output logic                                 rd_en,
   output logic [AW-1:0]                        rd_addr,
   input  wire logic [DW-1:0]                   rd_data,
   output logic                                 wr_en,
   output logic [AW-1:0]                        wr_addr,
   output logic [DW-1:0]                        wr_data
);

   localparam int LW  = (CHANNEL_DEPTH > 1) ? $clog2(CHANNEL_DEPTH) : 1;
   localparam int CW  = $clog2(CHANNEL_DEPTH + 1);
   localparam int CIW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int TW  = bsi_pkg::TAG_W;

   bsi_pkg::seq_state_type state_ff, state_in;
   bsi_pkg::op_type        op_ff, op_in;
   logic signed [ENERGY_WIDTH-1:0]   energy_ff, energy_in;
   logic [TW-1:0]                    tag_ff, tag_in;
   logic [bsi_pkg::CHIDX_W-1:0]      ch_ff, ch_in;
   logic [bsi_pkg::CHIDX_W-1:0]      nch_ff, nch_in;
   logic [CW-1:0]                    lim_ff, lim_in;
   logic [LW-1:0]                    cur_ff, cur_in;
   logic [LW-1:0]                    prev_ff, prev_in;
   logic [TW-1:0]                    prev_tag_ff, prev_tag_in;
   logic signed [ENERGY_WIDTH-1:0]   prev_energy_ff, prev_energy_in;
   logic [CW-1:0]                    pos_ff, pos_in;

   logic [CW-1:0] fill_ff [MAX_CHANNELS];
   logic [LW-1:0] head_ff [MAX_CHANNELS];
   logic          fill_clear, fill_inc, head_set;

   logic [CIW-1:0]                   ch_idx;
   logic [CW-1:0]                    fill_sel;
   logic [CW-1:0]                    n_sel;
   logic [CW-1:0]                    pos_next;
   logic signed [ENERGY_WIDTH-1:0]   rd_energy;
   logic [TW-1:0]                    rd_tag;
   logic [LW-1:0]                    rd_next;
   logic [bsi_pkg::LIMIT_W:0]        lim_wide;

   assign ch_idx    = CIW'(ch_ff);
   assign fill_sel  = fill_ff[ch_idx];
   assign n_sel     = (fill_sel < lim_ff) ? fill_sel : lim_ff;
   assign pos_next  = pos_ff + CW'(1);
   assign rd_energy = rd_data[ENERGY_WIDTH-1:0];
   assign rd_tag    = rd_data[ENERGY_WIDTH +: TW];
   assign rd_next   = rd_data[ENERGY_WIDTH+TW +: LW];
   assign lim_wide  = (bsi_pkg::LIMIT_W+1)'(in_limit);

   function automatic logic [AW-1:0] slot_addr(input logic [CIW-1:0] ch,
                                                input logic [LW-1:0] idx);
      slot_addr = AW'(ch) * AW'(CHANNEL_DEPTH) + AW'(idx);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bsi_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      energy_ff      <= energy_in;
      tag_ff         <= tag_in;
      ch_ff          <= ch_in;
      nch_ff         <= nch_in;
      lim_ff         <= lim_in;
      cur_ff         <= cur_in;
      prev_ff        <= prev_in;
      prev_tag_ff    <= prev_tag_in;
      prev_energy_ff <= prev_energy_in;
      pos_ff         <= pos_in;
   end

   // per-channel fill counts and list heads
   always_ff @(posedge clock) begin
      if (reset || fill_clear) begin
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            fill_ff[i] <= '0;
         end
      end else if (fill_inc) begin
         fill_ff[ch_idx] <= fill_sel + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (head_set) begin
         head_ff[ch_idx] <= LW'(fill_sel);
      end
   end

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      energy_in      = energy_ff;
      tag_in         = tag_ff;
      ch_in          = ch_ff;
      nch_in         = nch_ff;
      lim_in         = lim_ff;
      cur_in         = cur_ff;
      prev_in        = prev_ff;
      prev_tag_in    = prev_tag_ff;
      prev_energy_in = prev_energy_ff;
      pos_in         = pos_ff;
      fill_clear     = 1'b0;
      fill_inc       = 1'b0;
      head_set       = 1'b0;
      push           = 1'b0;
      push_ctl       = '0;
      push_energy    = '0;
      rd_en          = 1'b0;
      rd_addr        = slot_addr(ch_idx, cur_ff);
      wr_en          = 1'b0;
      wr_addr        = slot_addr(ch_idx, LW'(fill_sel));
      wr_data        = {((pos_ff < fill_sel) ? cur_ff : LW'(0)), tag_ff, energy_ff};
      busy           = (state_ff != bsi_pkg::ST_IDLE);

      case (state_ff)
         bsi_pkg::ST_IDLE: begin
            if (start) begin
               op_in     = in_op;
               energy_in = in_energy;
               tag_in    = in_tag;
               ch_in     = in_ch;
               nch_in    = in_nch;
               if (lim_wide == '0 || lim_wide > (bsi_pkg::LIMIT_W+1)'(CHANNEL_DEPTH)) begin
                  lim_in = CW'(CHANNEL_DEPTH);
               end else begin
                  lim_in = CW'(in_limit);
               end
               state_in = bsi_pkg::ST_CHECK;
            end
         end

         bsi_pkg::ST_CHECK: begin
            pos_in = '0;
            cur_in = head_ff[ch_idx];
            case (op_ff)
               bsi_pkg::OP_INSERT, bsi_pkg::OP_READ: begin
                  if (ch_ff >= nch_ff) begin
                     if (can_push) begin
                        push            = 1'b1;
                        push_ctl.status = bsi_pkg::STATUS_RANGE;
                        push_ctl.last   = 1'b1;
                        state_in        = bsi_pkg::ST_IDLE;
                     end
                  end else if (op_ff == bsi_pkg::OP_INSERT) begin
                     if (fill_sel >= CW'(CHANNEL_DEPTH)) begin
                        if (can_push) begin
                           push             = 1'b1;
                           push_ctl.status  = bsi_pkg::STATUS_FULL;
                           push_ctl.channel = bsi_pkg::CHAN_W'(ch_ff);
                           push_ctl.last    = 1'b1;
                           state_in         = bsi_pkg::ST_IDLE;
                        end
                     end else if (fill_sel == '0) begin
                        state_in = bsi_pkg::ST_WRITE;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = slot_addr(ch_idx, head_ff[ch_idx]);
                        state_in = bsi_pkg::ST_WALK;
                     end
                  end else begin
                     if (fill_sel == '0) begin
                        if (can_push) begin
                           push             = 1'b1;
                           push_ctl.channel = bsi_pkg::CHAN_W'(ch_ff);
                           push_ctl.last    = 1'b1;
                           state_in         = bsi_pkg::ST_IDLE;
                        end
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = slot_addr(ch_idx, head_ff[ch_idx]);
                        state_in = bsi_pkg::ST_READ;
                     end
                  end
               end
               bsi_pkg::OP_CLEAR: begin
                  if (can_push) begin
                     fill_clear    = 1'b1;
                     push          = 1'b1;
                     push_ctl.last = 1'b1;
                     state_in      = bsi_pkg::ST_IDLE;
                  end
               end
               default: begin
                  state_in = bsi_pkg::ST_IDLE;
               end
            endcase
         end

         // entry at position pos is on the read port
         bsi_pkg::ST_WALK: begin
            if (energy_ff < rd_energy) begin
               state_in = bsi_pkg::ST_WRITE;
            end else begin
               prev_in        = cur_ff;
               prev_tag_in    = rd_tag;
               prev_energy_in = rd_energy;
               pos_in         = pos_next;
               if (pos_next == fill_sel) begin
                  state_in = bsi_pkg::ST_WRITE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = slot_addr(ch_idx, rd_next);
                  cur_in  = rd_next;
               end
            end
         end

         // new entry goes to the slot numbered by the fill count
         bsi_pkg::ST_WRITE: begin
            wr_en = 1'b1;
            if (pos_ff == '0) begin
               head_set = 1'b1;
               state_in = bsi_pkg::ST_RESP;
            end else begin
               state_in = bsi_pkg::ST_LINK;
            end
         end

         bsi_pkg::ST_LINK: begin
            wr_en    = 1'b1;
            wr_addr  = slot_addr(ch_idx, prev_ff);
            wr_data  = {LW'(fill_sel), prev_tag_ff, prev_energy_ff};
            state_in = bsi_pkg::ST_RESP;
         end

         bsi_pkg::ST_RESP: begin
            if (can_push) begin
               fill_inc         = 1'b1;
               push             = 1'b1;
               push_ctl.channel = bsi_pkg::CHAN_W'(ch_ff);
               push_ctl.rank    = bsi_pkg::RANK_W'(pos_ff);
               push_ctl.last    = 1'b1;
               state_in         = bsi_pkg::ST_IDLE;
            end
         end

         // read data holds while the output is stalled
         bsi_pkg::ST_READ: begin
            if (can_push) begin
               push                 = 1'b1;
               push_ctl.channel     = bsi_pkg::CHAN_W'(ch_ff);
               push_ctl.tag         = rd_tag;
               push_ctl.rank        = bsi_pkg::RANK_W'(pos_ff);
               push_ctl.entry_valid = 1'b1;
               push_ctl.last        = (pos_next == n_sel);
               push_energy          = rd_energy;
               pos_in               = pos_next;
               if (pos_next == n_sel) begin
                  state_in = bsi_pkg::ST_IDLE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = slot_addr(ch_idx, rd_next);
               end
            end
         end

         default: begin
            state_in = bsi_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

### rtl/core/binned_sorted_insert_top.sv
// top level of the binned sorted insert block
`default_nettype none
// Keeps up to MAX_CHANNELS energy-ordered lists of CHANNEL_DEPTH entries each, as linked
// lists in one synchronous entry memory (energy, tag, next link). An insert transfer
// (tuser op 0) bins the entry by spin numbers and links it in after any equal energies;
// it walks the list one entry per cycle through the memory's read port, reading at most
// the fill count of entries (32 at default) and ending early at the first larger energy,
// then writes the entry and, whenever the new one does not land at the head, links it
// in behind an earlier entry. A readout (op 1) emits one result per cycle while the
// output is not stalled, from the list head, up to the readout limit. A clear (op 2)
// resets all fill counts at once; no memory sweep is needed after reset. Op 3 is
// dropped without a result. One item is worked at a time; req_tready is high only while
// the sequencer is idle. Results sit in an output register so a finished result can
// wait while the next item enters. Configuration must be written over the csr_ port
// only while the block is idle; the block itself does not enforce this.
module binned_sorted_insert_top #(
   parameter int MAX_CHANNELS  = bsi_pkg::MAX_CHANNELS_DEF,
   parameter int CHANNEL_DEPTH = bsi_pkg::CHANNEL_DEPTH_DEF,
   parameter int ENERGY_WIDTH  = bsi_pkg::ENERGY_WIDTH_DEF,
   localparam int REQ_BITS = ENERGY_WIDTH + 2 * bsi_pkg::SPIN_W + bsi_pkg::TAG_W
                             + bsi_pkg::RCH_W,
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_BITS = bsi_pkg::CHAN_W + ENERGY_WIDTH + bsi_pkg::TAG_W
                             + bsi_pkg::RANK_W,
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // energy, twice_total_spin, twice_spin_z, state_tag, read_channel (low to high)
   input  wire logic [REQ_W-1:0]                  req_tdata,
   // op
   input  wire logic [bsi_pkg::OP_W-1:0]          req_tuser,
   // result channel
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // channel, out_energy, out_tag, rank (low to high)
   output logic [RSP_W-1:0]                       rsp_tdata,
   // status, entry_valid (low to high)
   output logic [bsi_pkg::STATUS_W:0]             rsp_tuser,
   output logic                                   rsp_tlast,
   // configuration write channel
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [bsi_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [bsi_pkg::CSR_DAT_W-1:0]     csr_data
);

   localparam int LW    = (CHANNEL_DEPTH > 1) ? $clog2(CHANNEL_DEPTH) : 1;
   localparam int WORDS = MAX_CHANNELS * CHANNEL_DEPTH;
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int DW    = LW + bsi_pkg::TAG_W + ENERGY_WIDTH;
   localparam int SW    = bsi_pkg::SPIN_W;
   localparam int CHW   = bsi_pkg::CHIDX_W;

   // request field offsets
   localparam int TS_LO  = ENERGY_WIDTH;
   localparam int SZ_LO  = TS_LO + SW;
   localparam int TAG_LO = SZ_LO + SW;
   localparam int RCH_LO = TAG_LO + bsi_pkg::TAG_W;

   // configuration registers
   bsi_pkg::mode_type              mode_ff;
   logic [bsi_pkg::PCOUNT_W-1:0]   pcount_ff;
   logic [bsi_pkg::LIMIT_W-1:0]    limit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= bsi_pkg::MODE_TRIANGULAR;
         pcount_ff <= '0;
         limit_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            bsi_pkg::REG_MODE:   mode_ff   <= bsi_pkg::mode_type'(csr_data[bsi_pkg::MODE_W-1:0]);
            bsi_pkg::REG_PCOUNT: pcount_ff <= csr_data[bsi_pkg::PCOUNT_W-1:0];
            bsi_pkg::REG_LIMIT:  limit_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // channels in use, capped at the channel count
   logic [3:0]      half_p;
   logic [CHW:0]    tri_p;
   logic [CHW:0]    nch_raw;
   logic [CHW-1:0]  nch;

   assign half_p = pcount_ff[bsi_pkg::PCOUNT_W-1:1];
   assign tri_p  = ((CHW+1)'(half_p) + (CHW+1)'(1)) * ((CHW+1)'(half_p) + (CHW+1)'(2)) >> 1;

   always_comb begin
      case (mode_ff)
         bsi_pkg::MODE_TRIANGULAR: nch_raw = tri_p;
         bsi_pkg::MODE_PROJECTION: nch_raw = (CHW+1)'(half_p) + (CHW+1)'(1);
         bsi_pkg::MODE_SINGLE:     nch_raw = (CHW+1)'(1);
         default:                  nch_raw = '0;
      endcase
   end

   assign nch = (nch_raw > (CHW+1)'(MAX_CHANNELS)) ? CHW'(MAX_CHANNELS) : CHW'(nch_raw);

   // channel of the incoming request
   logic [SW-1:0]   ts, sz;
   logic [3:0]      half_z, t_half;
   logic [CHW-1:0]  tri_t;
   logic [CHW-1:0]  ch_bin;
   logic [CHW-1:0]  ch_sel;
   bsi_pkg::op_type req_op;

   assign ts     = req_tdata[TS_LO +: SW];
   assign sz     = req_tdata[SZ_LO +: SW];
   assign half_z = sz[SW-1:1];
   assign t_half = 4'((ts - SW'(2)) >> 1);
   assign tri_t  = CHW'((({4'd0, t_half} + 8'd1) * ({4'd0, t_half} + 8'd2)) >> 1);
   assign req_op = bsi_pkg::op_type'(req_tuser);

   always_comb begin
      case (mode_ff)
         bsi_pkg::MODE_TRIANGULAR: begin
            if (ts < SW'(2)) begin
               ch_bin = CHW'(half_z);
            end else begin
               ch_bin = tri_t + CHW'(half_z);
            end
         end
         bsi_pkg::MODE_PROJECTION: ch_bin = CHW'(half_z);
         default:                  ch_bin = '0;
      endcase
   end

   // a readout names its channel directly
   assign ch_sel = (req_op == bsi_pkg::OP_READ)
                   ? CHW'(req_tdata[RCH_LO +: bsi_pkg::RCH_W]) : ch_bin;

   // sequencer and entry memory
   logic                             seq_busy;
   logic                             push;
   bsi_pkg::rsp_ctl_type             push_ctl;
   logic signed [ENERGY_WIDTH-1:0]   push_energy;
   logic                             can_push;
   logic                             rd_en, wr_en;
   logic [AW-1:0]                    rd_addr, wr_addr;
   logic [DW-1:0]                    rd_data, wr_data;
   logic                             start;

   assign req_tready = !seq_busy;
   assign start      = req_tvalid && req_tready;

   bsi_seq #(
      .MAX_CHANNELS  (MAX_CHANNELS),
      .CHANNEL_DEPTH (CHANNEL_DEPTH),
      .ENERGY_WIDTH  (ENERGY_WIDTH),
      .AW            (AW),
      .DW            (DW)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .in_op       (req_op),
      .in_energy   (req_tdata[ENERGY_WIDTH-1:0]),
      .in_tag      (req_tdata[TAG_LO +: bsi_pkg::TAG_W]),
      .in_ch       (ch_sel),
      .in_nch      (nch),
      .in_limit    (limit_ff),
      .can_push    (can_push),
      .busy        (seq_busy),
      .push        (push),
      .push_ctl    (push_ctl),
      .push_energy (push_energy),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data)
   );

   bsi_entry_mem #(
      .WORDS (WORDS),
      .AW    (AW),
      .DW    (DW)
   ) u_mem (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // output register, free when empty or when its transfer completes
   logic                             rsp_valid_ff;
   bsi_pkg::rsp_ctl_type             rsp_ctl_ff;
   logic signed [ENERGY_WIDTH-1:0]   rsp_energy_ff;

   assign can_push = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_ctl_ff    <= push_ctl;
         rsp_energy_ff <= push_energy;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_ctl_ff.rank, rsp_ctl_ff.tag, rsp_energy_ff,
                               rsp_ctl_ff.channel});
   assign rsp_tuser  = {rsp_ctl_ff.entry_valid, rsp_ctl_ff.status};
   assign rsp_tlast  = rsp_ctl_ff.last;

endmodule
`default_nettype wire
